>>> rtl/ordq_pkg.sv
// Shared types, constants and index helpers for the overwriting ring deque.
// Used by overwriting_ring_deque_unit; depends on nothing.
package ordq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [3:0] {
        ACT_PUSH_BACK  = 4'd0,
        ACT_PUSH_FRONT = 4'd1,
        ACT_POP_FRONT  = 4'd2,
        ACT_POP_BACK   = 4'd3,
        ACT_READ_AT    = 4'd4,
        ACT_WRITE_AT   = 4'd5,
        ACT_INSERT     = 4'd6,
        ACT_ERASE      = 4'd7,
        ACT_CLEAR      = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_RANGE   = 2'd2,
        ST_ZEROCAP = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POPW,
        S_MVRD,
        S_MVWR,
        S_FIN,
        S_RDF,
        S_RDB,
        S_CAPB,
        S_OUT
    } state_t;

    // Physical slot of a logical index, wrapped at the capacity in use.
    function automatic idx_t phys_idx(idx_t head, cnt_t lidx, cnt_t cap);
        logic [CNT_W:0] s;
        s = {1'b0, CNT_W'(head)} + {1'b0, lidx};
        if (cap == '0) begin
            s = '0;
        end else if (s >= {1'b0, cap}) begin
            s = s - {1'b0, cap};
        end
        return idx_t'(s);
    endfunction

    // Slot n places before a, wrapped at the capacity in use.
    function automatic idx_t wrap_dec(idx_t a, cnt_t n, cnt_t cap);
        logic [CNT_W:0] s;
        s = {1'b0, CNT_W'(a)} + {1'b0, cap} - {1'b0, n};
        if (cap == '0) begin
            s = '0;
        end else if (s >= {1'b0, cap}) begin
            s = s - {1'b0, cap};
        end
        return idx_t'(s);
    endfunction

endpackage

>>> rtl/ordq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
module ordq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/overwriting_ring_deque_unit.sv
// Overwriting ring deque: one request at a time, state held in ordq_ram.
// Each request passes S_EXEC, S_RDF, S_RDB and S_CAPB to S_OUT; a pop or read that
// succeeds adds S_POPW, and an insert or erase that changes the contents adds S_MVRD
// and S_FIN, plus S_MVWR and S_MVRD per shifted entry (one RAM read and one write each).
// A new request is accepted in the cycle after the previous result has been taken.
// Reset (synchronous, active low) empties the deque and sets capacity to 16;
// slot contents are not cleared. Depends on ordq_pkg and ordq_ram.
module overwriting_ring_deque_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[3:0], item_value[35:4], position[40:36], range_end[45:41], zero pad
    input  logic [47:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_value[31:0], status[33:32], element_count[38:34], front_value[70:39],
    // back_value[102:71], zero pad
    output logic [103:0] m_tdata
);

    ordq_pkg::state_t  state_reg, state_next;
    ordq_pkg::cnt_t    cap_reg, cap_next;
    ordq_pkg::idx_t    head_reg, head_next;
    ordq_pkg::idx_t    tail_reg, tail_next;
    ordq_pkg::cnt_t    cnt_reg, cnt_next;
    ordq_pkg::action_t act_reg, act_next;
    ordq_pkg::word_t   item_reg, item_next;
    ordq_pkg::cnt_t    pos_reg, pos_next;
    ordq_pkg::cnt_t    rend_reg, rend_next;
    ordq_pkg::cnt_t    src_reg, src_next;
    ordq_pkg::cnt_t    dst_reg, dst_next;
    ordq_pkg::cnt_t    mv_reg, mv_next;
    logic              up_reg, up_next;
    ordq_pkg::word_t   rd_reg, rd_next;
    ordq_pkg::status_t status_reg, status_next;
    ordq_pkg::word_t   front_reg, front_next;
    ordq_pkg::word_t   back_reg, back_next;

    logic              ram_we;
    ordq_pkg::idx_t    ram_waddr;
    ordq_pkg::word_t   ram_wdata;
    ordq_pkg::idx_t    ram_raddr;
    ordq_pkg::word_t   ram_rdata;

    logic              full, zerocap, empty;
    logic              s_fire, m_fire;
    ordq_pkg::cnt_t    gone;

    assign s_fire  = s_tvalid && s_tready;
    assign m_fire  = m_tvalid && m_tready;
    assign full    = (cnt_reg >= cap_reg);
    assign zerocap = (cap_reg == '0);
    assign empty   = (cnt_reg == '0);
    assign gone    = rend_reg - pos_reg;

    assign s_tready = (state_reg == ordq_pkg::S_IDLE);
    assign m_tvalid = (state_reg == ordq_pkg::S_OUT);
    assign m_tdata  = {1'b0, back_reg, front_reg, cnt_reg, status_reg, rd_reg};

    ordq_ram #(
        .WIDTH (ordq_pkg::WORD_BITS),
        .DEPTH (ordq_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ordq_pkg::S_IDLE: begin
                if (s_fire) state_next = ordq_pkg::S_EXEC;
            end
            ordq_pkg::S_EXEC: begin
                state_next = ordq_pkg::S_RDF;
                unique case (act_reg)
                    ordq_pkg::ACT_POP_FRONT, ordq_pkg::ACT_POP_BACK: begin
                        if (!empty) state_next = ordq_pkg::S_POPW;
                    end
                    ordq_pkg::ACT_READ_AT: begin
                        if (pos_reg < cnt_reg) state_next = ordq_pkg::S_POPW;
                    end
                    ordq_pkg::ACT_INSERT: begin
                        if (!zerocap && pos_reg <= cnt_reg && !(full && pos_reg == '0)) begin
                            state_next = ordq_pkg::S_MVRD;
                        end
                    end
                    ordq_pkg::ACT_ERASE: begin
                        if (pos_reg <= cnt_reg && rend_reg <= cnt_reg && pos_reg < rend_reg) begin
                            state_next = ordq_pkg::S_MVRD;
                        end
                    end
                    default: state_next = ordq_pkg::S_RDF;
                endcase
            end
            ordq_pkg::S_POPW: state_next = ordq_pkg::S_RDF;
            ordq_pkg::S_MVRD: begin
                state_next = (mv_reg == '0) ? ordq_pkg::S_FIN : ordq_pkg::S_MVWR;
            end
            ordq_pkg::S_MVWR: state_next = ordq_pkg::S_MVRD;
            ordq_pkg::S_FIN:  state_next = ordq_pkg::S_RDF;
            ordq_pkg::S_RDF:  state_next = ordq_pkg::S_RDB;
            ordq_pkg::S_RDB:  state_next = ordq_pkg::S_CAPB;
            ordq_pkg::S_CAPB: state_next = ordq_pkg::S_OUT;
            ordq_pkg::S_OUT: begin
                if (m_fire) state_next = ordq_pkg::S_IDLE;
            end
            default: state_next = ordq_pkg::S_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb begin
        cap_next    = cap_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        act_next    = act_reg;
        item_next   = item_reg;
        pos_next    = pos_reg;
        rend_next   = rend_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        mv_next     = mv_reg;
        up_next     = up_reg;
        rd_next     = rd_reg;
        status_next = status_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        ram_we      = 1'b0;
        ram_waddr   = head_reg;
        ram_wdata   = item_reg;
        ram_raddr   = head_reg;

        unique case (state_reg)
            ordq_pkg::S_IDLE: begin
                if (s_fire) begin
                    act_next  = ordq_pkg::action_t'(s_tdata[3:0]);
                    item_next = s_tdata[35:4];
                    pos_next  = s_tdata[40:36];
                    rend_next = s_tdata[45:41];
                end
                if (cfg_we) begin
                    cap_next  = (cfg_wdata > ordq_pkg::cnt_t'(ordq_pkg::DEPTH))
                                ? ordq_pkg::cnt_t'(ordq_pkg::DEPTH) : cfg_wdata;
                    head_next = '0;
                    tail_next = '0;
                    cnt_next  = '0;
                end
            end
            ordq_pkg::S_EXEC: begin
                rd_next     = '0;
                status_next = ordq_pkg::ST_OK;
                unique case (act_reg)
                    ordq_pkg::ACT_PUSH_BACK: begin
                        if (zerocap) begin
                            status_next = ordq_pkg::ST_ZEROCAP;
                        end else begin
                            tail_next = empty ? tail_reg : ordq_pkg::phys_idx(tail_reg, 5'd1, cap_reg);
                            ram_we    = 1'b1;
                            ram_waddr = tail_next;
                            if (full) head_next = ordq_pkg::phys_idx(head_reg, 5'd1, cap_reg);
                            else      cnt_next  = cnt_reg + 5'd1;
                        end
                    end
                    ordq_pkg::ACT_PUSH_FRONT: begin
                        if (zerocap) begin
                            status_next = ordq_pkg::ST_ZEROCAP;
                        end else begin
                            head_next = empty ? head_reg : ordq_pkg::wrap_dec(head_reg, 5'd1, cap_reg);
                            ram_we    = 1'b1;
                            ram_waddr = head_next;
                            if (full) tail_next = ordq_pkg::wrap_dec(tail_reg, 5'd1, cap_reg);
                            else      cnt_next  = cnt_reg + 5'd1;
                        end
                    end
                    ordq_pkg::ACT_POP_FRONT: begin
                        ram_raddr = head_reg;
                        if (empty) begin
                            status_next = ordq_pkg::ST_EMPTY;
                        end else begin
                            cnt_next  = cnt_reg - 5'd1;
                            head_next = (cnt_reg == 5'd1) ? tail_reg
                                        : ordq_pkg::phys_idx(head_reg, 5'd1, cap_reg);
                        end
                    end
                    ordq_pkg::ACT_POP_BACK: begin
                        ram_raddr = tail_reg;
                        if (empty) begin
                            status_next = ordq_pkg::ST_EMPTY;
                        end else begin
                            cnt_next  = cnt_reg - 5'd1;
                            tail_next = (cnt_reg == 5'd1) ? head_reg
                                        : ordq_pkg::wrap_dec(tail_reg, 5'd1, cap_reg);
                        end
                    end
                    ordq_pkg::ACT_READ_AT: begin
                        ram_raddr = ordq_pkg::phys_idx(head_reg, pos_reg, cap_reg);
                        if (pos_reg >= cnt_reg) status_next = ordq_pkg::ST_RANGE;
                    end
                    ordq_pkg::ACT_WRITE_AT: begin
                        if (pos_reg >= cnt_reg) begin
                            status_next = ordq_pkg::ST_RANGE;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = ordq_pkg::phys_idx(head_reg, pos_reg, cap_reg);
                        end
                    end
                    ordq_pkg::ACT_INSERT: begin
                        // Entries from the position upward move one place toward the back,
                        // starting with the last one.
                        if (zerocap)               status_next = ordq_pkg::ST_ZEROCAP;
                        else if (pos_reg > cnt_reg) status_next = ordq_pkg::ST_RANGE;
                        src_next = cnt_reg - 5'd1;
                        dst_next = cnt_reg;
                        mv_next  = cnt_reg - pos_reg;
                        up_next  = 1'b0;
                    end
                    ordq_pkg::ACT_ERASE: begin
                        if (pos_reg > cnt_reg || rend_reg > cnt_reg) begin
                            status_next = ordq_pkg::ST_RANGE;
                        end
                        src_next = rend_reg;
                        dst_next = pos_reg;
                        mv_next  = cnt_reg - rend_reg;
                        up_next  = 1'b1;
                    end
                    ordq_pkg::ACT_CLEAR: begin
                        cnt_next  = '0;
                        tail_next = head_reg;
                    end
                    default: begin
                        status_next = ordq_pkg::ST_OK;
                    end
                endcase
            end
            ordq_pkg::S_POPW: begin
                rd_next = ram_rdata;
            end
            ordq_pkg::S_MVRD: begin
                ram_raddr = ordq_pkg::phys_idx(head_reg, src_reg, cap_reg);
            end
            ordq_pkg::S_MVWR: begin
                ram_we    = 1'b1;
                ram_waddr = ordq_pkg::phys_idx(head_reg, dst_reg, cap_reg);
                ram_wdata = ram_rdata;
                src_next  = up_reg ? src_reg + 5'd1 : src_reg - 5'd1;
                dst_next  = up_reg ? dst_reg + 5'd1 : dst_reg - 5'd1;
                mv_next   = mv_reg - 5'd1;
            end
            ordq_pkg::S_FIN: begin
                if (act_reg == ordq_pkg::ACT_INSERT) begin
                    ram_we    = 1'b1;
                    ram_waddr = ordq_pkg::phys_idx(head_reg, pos_reg, cap_reg);
                    if (full) begin
                        // The oldest entry is dropped: its slot now holds the back entry.
                        head_next = ordq_pkg::phys_idx(head_reg, 5'd1, cap_reg);
                        tail_next = head_reg;
                    end else begin
                        cnt_next  = cnt_reg + 5'd1;
                        tail_next = ordq_pkg::phys_idx(head_reg, cnt_reg, cap_reg);
                    end
                end else begin
                    cnt_next  = cnt_reg - gone;
                    tail_next = (cnt_reg == gone) ? head_reg
                                : ordq_pkg::wrap_dec(tail_reg, gone, cap_reg);
                end
            end
            ordq_pkg::S_RDF: begin
                ram_raddr = head_reg;
            end
            ordq_pkg::S_RDB: begin
                front_next = empty ? '0 : ram_rdata;
                ram_raddr  = tail_reg;
            end
            ordq_pkg::S_CAPB: begin
                back_next = empty ? '0 : ram_rdata;
            end
            ordq_pkg::S_OUT: begin
                ram_raddr = head_reg;
            end
            default: begin
                ram_raddr = head_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ordq_pkg::S_IDLE;
            cap_reg   <= ordq_pkg::cnt_t'(ordq_pkg::DEPTH);
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        item_reg   <= item_next;
        pos_reg    <= pos_next;
        rend_reg   <= rend_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        mv_reg     <= mv_next;
        up_reg     <= up_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
        front_reg  <= front_next;
        back_reg   <= back_next;
    end

endmodule
